@@ hw/rtl/stp_pkg.sv @@
// Package for the spring torque polynomial block: widths, codes, FSM state type,
// control struct of the multiply-accumulate unit and the curve coefficient ROM.
// No dependencies.
package stp_pkg;

    localparam int ANGLE_W   = 24;
    localparam int DIR_W     = 2;
    localparam int TORQUE_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int TYPE_W    = 3;
    localparam int COEF_W    = 32;
    localparam int ACC_W     = 40;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 42;
    localparam int ROUND_SH  = 22;
    localparam int ROM_AW    = 7;
    localparam int CURVE_W   = 3;
    localparam int LEN_W     = 4;

    localparam int MAX_TERMS_DEF = 10;

    localparam logic [TYPE_W-1:0] SPRING_NONE = 3'd4;
    localparam logic [DIR_W-1:0]  DIR_DEC     = 2'd1;

    localparam logic signed [SUM_W-1:0]    ACC_LIM   = 42'sd549755813887;
    localparam logic signed [PROD_W-1:0]   HALF_STEP = 64'sd2097152;
    localparam logic signed [ACC_W-1:0]    TQ_MAX    = 40'sd2147483647;
    localparam logic signed [ACC_W-1:0]    TQ_MIN    = -40'sd2147483648;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_DIR  = 2'd1,
        ST_NO_TYPE = 2'd2
    } stp_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DONE
    } stp_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
    } stp_mac_ctrl_t;

    // Curve order: blue inc, blue dec, green inc, green dec,
    // red inc, red dec, yellow inc, yellow dec.
    function automatic logic [ROM_AW-1:0] curve_start(input logic [CURVE_W-1:0] c);
        logic [ROM_AW-1:0] r;
        case (c)
            3'd0:    r = 7'd0;
            3'd1:    r = 7'd10;
            3'd2:    r = 7'd17;
            3'd3:    r = 7'd26;
            3'd4:    r = 7'd33;
            3'd5:    r = 7'd41;
            3'd6:    r = 7'd49;
            default: r = 7'd59;
        endcase
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] curve_len(input logic [CURVE_W-1:0] c);
        logic [LEN_W-1:0] r;
        case (c)
            3'd0:    r = 4'd10;
            3'd1:    r = 4'd7;
            3'd2:    r = 4'd9;
            3'd3:    r = 4'd7;
            3'd4:    r = 4'd8;
            3'd5:    r = 4'd8;
            3'd6:    r = 4'd10;
            default: r = 4'd7;
        endcase
        return r;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_at(input logic [ROM_AW-1:0] i);
        logic signed [COEF_W-1:0] r;
        case (i)
            // blue increasing
            7'd0:    r = 32'sd3958;
            7'd1:    r = 32'sd1446412;
            7'd2:    r = -32'sd21534699;
            7'd3:    r = 32'sd183732467;
            7'd4:    r = -32'sd480634422;
            7'd5:    r = 32'sd618855175;
            7'd6:    r = -32'sd447223926;
            7'd7:    r = 32'sd185275503;
            7'd8:    r = -32'sd41191722;
            7'd9:    r = 32'sd3816992;
            // blue decreasing
            7'd10:   r = -32'sd32261;
            7'd11:   r = -32'sd285347;
            7'd12:   r = 32'sd28123180;
            7'd13:   r = -32'sd52319023;
            7'd14:   r = 32'sd40536218;
            7'd15:   r = -32'sd14602199;
            7'd16:   r = 32'sd2002374;
            // green increasing
            7'd17:   r = 32'sd9275;
            7'd18:   r = -32'sd3712382;
            7'd19:   r = 32'sd41092568;
            7'd20:   r = -32'sd88612438;
            7'd21:   r = 32'sd91907185;
            7'd22:   r = -32'sd53659869;
            7'd23:   r = 32'sd18499441;
            7'd24:   r = -32'sd3706699;
            7'd25:   r = 32'sd353340;
            // green decreasing
            7'd26:   r = -32'sd31804;
            7'd27:   r = -32'sd142560;
            7'd28:   r = 32'sd27267698;
            7'd29:   r = -32'sd54531245;
            7'd30:   r = 32'sd44837936;
            7'd31:   r = -32'sd16993421;
            7'd32:   r = 32'sd2438094;
            // red increasing
            7'd33:   r = 32'sd8939;
            7'd34:   r = -32'sd3918543;
            7'd35:   r = 32'sd44646848;
            7'd36:   r = -32'sd104528909;
            7'd37:   r = 32'sd115008166;
            7'd38:   r = -32'sd66628995;
            7'd39:   r = 32'sd19538507;
            7'd40:   r = -32'sd2278943;
            // red decreasing
            7'd41:   r = -32'sd1745;
            7'd42:   r = -32'sd3091199;
            7'd43:   r = 32'sd49509698;
            7'd44:   r = -32'sd122283092;
            7'd45:   r = 32'sd140332144;
            7'd46:   r = -32'sd84804693;
            7'd47:   r = 32'sd26009569;
            7'd48:   r = -32'sd3186979;
            // yellow increasing
            7'd49:   r = 32'sd399;
            7'd50:   r = -32'sd3035149;
            7'd51:   r = 32'sd37828675;
            7'd52:   r = -32'sd67906143;
            7'd53:   r = -32'sd20200140;
            7'd54:   r = 32'sd193147811;
            7'd55:   r = -32'sd251361661;
            7'd56:   r = 32'sd154813210;
            7'd57:   r = -32'sd47956199;
            7'd58:   r = 32'sd6042465;
            // yellow decreasing
            7'd59:   r = -32'sd17379;
            7'd60:   r = 32'sd60273;
            7'd61:   r = 32'sd24987353;
            7'd62:   r = -32'sd61455449;
            7'd63:   r = 32'sd62729639;
            7'd64:   r = -32'sd29820969;
            7'd65:   r = 32'sd5402925;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/stp_ifs.sv @@
// Valid/ready channel interfaces of the spring torque polynomial block:
// angle input, torque result and spring-type configuration.
// Depends on stp_pkg.
interface stp_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [stp_pkg::ANGLE_W-1:0]  angle;
    logic        [stp_pkg::DIR_W-1:0]    direction;

    modport source (output valid, angle, direction, input ready);
    modport sink   (input valid, angle, direction, output ready);
endinterface

interface stp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [stp_pkg::TORQUE_W-1:0] torque;
    logic        [stp_pkg::STATUS_W-1:0] status;

    modport source (output valid, torque, status, input ready);
    modport sink   (input valid, torque, status, output ready);
endinterface

interface stp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [stp_pkg::TYPE_W-1:0]        data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/stp_mac.sv @@
// Shared multiply-accumulate unit for the Horner steps: a multiply step,
// then an add, round and clamp step. Depends on stp_pkg.
module stp_mac (
    input  logic                                 clk,
    input  stp_pkg::stp_mac_ctrl_t               ctrl,
    input  logic signed [stp_pkg::COEF_W-1:0]    coef,
    input  logic signed [stp_pkg::ANGLE_W-1:0]   angle,
    output logic signed [stp_pkg::ACC_W-1:0]     acc
);

    logic signed [stp_pkg::ACC_W-1:0]  acc_reg;
    logic signed [stp_pkg::ACC_W-1:0]  acc_next;
    logic signed [stp_pkg::PROD_W-1:0] prod_reg;
    logic signed [stp_pkg::PROD_W-1:0] prod_next;
    logic signed [stp_pkg::PROD_W-1:0] rnd;
    logic signed [stp_pkg::SUM_W-1:0]  sum;

    always_comb
    begin
        prod_next = prod_reg;
        if (ctrl.mul)
        begin
            prod_next = stp_pkg::PROD_W'(acc_reg) * stp_pkg::PROD_W'(angle);
        end
    end

    assign rnd = (prod_reg + stp_pkg::HALF_STEP) >>> stp_pkg::ROUND_SH;
    assign sum = stp_pkg::SUM_W'(coef) + rnd[stp_pkg::SUM_W-1:0];

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.load)
        begin
            acc_next = stp_pkg::ACC_W'(coef);
        end
        else if (ctrl.add)
        begin
            if (sum > stp_pkg::ACC_LIM)
            begin
                acc_next = stp_pkg::ACC_LIM[stp_pkg::ACC_W-1:0];
            end
            else if (sum < -stp_pkg::ACC_LIM)
            begin
                acc_next = -stp_pkg::ACC_LIM[stp_pkg::ACC_W-1:0];
            end
            else
            begin
                acc_next = sum[stp_pkg::ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ hw/rtl/spring_torque_polynomial.sv @@
// Top level of the spring torque polynomial block: sequencer, curve ROM lookup,
// configuration register and result register. Depends on stp_pkg, stp_ifs, stp_mac.
//
// Converts a joint angle into spring torque by Horner evaluation of one of eight
// fixed curves, chosen by the spring type register and the direction field. A
// word takes n - 1 Horner steps, where n is the number of terms of the chosen
// curve (7 to 10, capped at MAX_TERMS). The single multiply-accumulate unit does
// the multiply and then the add, round and clamp of each step; the result is then
// saturated and registered in the done state, which holds while the result
// register is still full. With no spring type or an unspecified direction the
// result (torque 0 and a status code) goes from acceptance straight to the done
// state. The input stays not ready while a word is under evaluation; a finished
// result waits in its own register, so the next word can be taken before it is
// collected.
module spring_torque_polynomial #(
    parameter int MAX_TERMS = stp_pkg::MAX_TERMS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    stp_cfg_if.sink       cfg,
    stp_in_if.sink        sample,
    stp_out_if.source     result
);

    localparam int KW = $clog2(MAX_TERMS);

    stp_pkg::stp_state_t                   state_reg;
    stp_pkg::stp_state_t                   state_next;
    logic [stp_pkg::TYPE_W-1:0]            spring_type_reg;
    logic [KW-1:0]                         k_reg;
    logic [KW-1:0]                         k_next;
    logic [stp_pkg::ROM_AW-1:0]            base_reg;
    logic [stp_pkg::ROM_AW-1:0]            base_next;
    logic signed [stp_pkg::ANGLE_W-1:0]    angle_reg;
    logic signed [stp_pkg::ANGLE_W-1:0]    angle_next;
    stp_pkg::stp_status_t                  status_reg;
    stp_pkg::stp_status_t                  status_next;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic signed [stp_pkg::TORQUE_W-1:0]   torque_reg;
    logic signed [stp_pkg::TORQUE_W-1:0]   torque_next;
    stp_pkg::stp_status_t                  out_status_reg;
    stp_pkg::stp_status_t                  out_status_next;

    stp_pkg::stp_mac_ctrl_t                mac_ctrl;
    logic signed [stp_pkg::COEF_W-1:0]     coef;
    logic signed [stp_pkg::ACC_W-1:0]      acc;
    logic [stp_pkg::CURVE_W-1:0]           curve;
    logic [stp_pkg::LEN_W-1:0]             len;
    logic [stp_pkg::ROM_AW-1:0]            start;
    logic [KW-1:0]                         last_k;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spring_type_reg <= stp_pkg::SPRING_NONE;
        end
        else if (cfg.valid)
        begin
            spring_type_reg <= cfg.data;
        end
    end

    assign curve  = {spring_type_reg[1:0], sample.direction[0]};
    assign len    = stp_pkg::curve_len(curve);
    assign start  = stp_pkg::curve_start(curve);
    assign last_k = (int'(len) > MAX_TERMS) ? KW'(MAX_TERMS - 1) : KW'(len - 4'd1);

    stp_mac u_mac (
        .clk   (clk),
        .ctrl  (mac_ctrl),
        .coef  (coef),
        .angle (angle_reg),
        .acc   (acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        base_reg       <= base_next;
        angle_reg      <= angle_next;
        status_reg     <= status_next;
        torque_reg     <= torque_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        base_next       = base_reg;
        angle_next      = angle_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        torque_next     = torque_reg;
        out_status_next = out_status_reg;
        mac_ctrl        = '0;
        coef            = '0;

        // drop the result once taken
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            stp_pkg::S_IDLE:
            begin
                if (sample.valid)
                begin
                    angle_next    = sample.angle;
                    mac_ctrl.load = 1'b1;
                    state_next    = stp_pkg::S_DONE;
                    if (spring_type_reg >= stp_pkg::SPRING_NONE)
                    begin
                        status_next = stp_pkg::ST_NO_TYPE;
                    end
                    else if (sample.direction > stp_pkg::DIR_DEC)
                    begin
                        status_next = stp_pkg::ST_NO_DIR;
                    end
                    else
                    begin
                        status_next = stp_pkg::ST_OK;
                        base_next   = start;
                        k_next      = last_k;
                        coef        = stp_pkg::coef_at(start + stp_pkg::ROM_AW'(last_k));
                        if (last_k != '0)
                        begin
                            state_next = stp_pkg::S_MUL;
                        end
                    end
                end
            end
            stp_pkg::S_MUL:
            begin
                mac_ctrl.mul = 1'b1;
                state_next   = stp_pkg::S_ADD;
            end
            stp_pkg::S_ADD:
            begin
                mac_ctrl.add = 1'b1;
                coef         = stp_pkg::coef_at(base_reg + stp_pkg::ROM_AW'(k_reg)
                                                - stp_pkg::ROM_AW'(1));
                k_next       = k_reg - KW'(1);
                state_next   = (k_reg == KW'(1)) ? stp_pkg::S_DONE : stp_pkg::S_MUL;
            end
            stp_pkg::S_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (acc > stp_pkg::TQ_MAX)
                    begin
                        torque_next = stp_pkg::TQ_MAX[stp_pkg::TORQUE_W-1:0];
                    end
                    else if (acc < stp_pkg::TQ_MIN)
                    begin
                        torque_next = stp_pkg::TQ_MIN[stp_pkg::TORQUE_W-1:0];
                    end
                    else
                    begin
                        torque_next = acc[stp_pkg::TORQUE_W-1:0];
                    end
                    state_next = stp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stp_pkg::S_IDLE;
            end
        endcase
    end

    assign sample.ready  = (state_reg == stp_pkg::S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.torque = torque_reg;
    assign result.status = out_status_reg;

    a_mul_has_terms: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == stp_pkg::S_MUL |-> k_reg != '0)
        else $error("multiply step with no term left");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("input ready right after an accepted word");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg) == stp_pkg::S_DONE)
        else $error("result appeared outside the done state");

    a_status_zero_torque: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != stp_pkg::ST_OK |-> result.torque == '0)
        else $error("non-zero torque with an error status");

endmodule

@@ dv/tb_spring_torque_polynomial.sv @@
`timescale 1ns / 1ps
// Testbench for spring_torque_polynomial: directed and random angle words with a
// local Horner predictor, random stalls on both channels. Depends on stp_pkg, stp_ifs.
module tb_spring_torque_polynomial;

    localparam int     CYCLE_LIMIT = 600000;
    localparam int     TERM_CAP    = stp_pkg::MAX_TERMS_DEF;
    localparam longint ACC_LIMIT   = 64'sd549755813887;
    localparam longint ROUND_HALF  = 64'sd2097152;
    localparam longint TORQUE_HI   = 64'sd2147483647;
    localparam longint TORQUE_LO   = -64'sd2147483648;
    localparam logic signed [stp_pkg::ANGLE_W-1:0] ANGLE_MAX = 24'sh7FFFFF;
    localparam logic signed [stp_pkg::ANGLE_W-1:0] ANGLE_MIN = 24'sh800000;
    localparam logic [stp_pkg::DIR_W-1:0] DIR_INC   = 2'd0;
    localparam logic [stp_pkg::DIR_W-1:0] DIR_NONE  = 2'd2;
    localparam logic [stp_pkg::DIR_W-1:0] DIR_NONE3 = 2'd3;

    localparam int CURVE_BASE  [0:7] = '{0, 10, 17, 26, 33, 41, 49, 59};
    localparam int CURVE_TERMS [0:7] = '{10, 7, 9, 7, 8, 8, 10, 7};
    localparam longint HORNER_COEF [0:65] = '{
        3958, 1446412, -21534699, 183732467, -480634422,
        618855175, -447223926, 185275503, -41191722, 3816992,
        -32261, -285347, 28123180, -52319023, 40536218, -14602199, 2002374,
        9275, -3712382, 41092568, -88612438, 91907185,
        -53659869, 18499441, -3706699, 353340,
        -31804, -142560, 27267698, -54531245, 44837936, -16993421, 2438094,
        8939, -3918543, 44646848, -104528909, 115008166,
        -66628995, 19538507, -2278943,
        -1745, -3091199, 49509698, -122283092, 140332144,
        -84804693, 26009569, -3186979,
        399, -3035149, 37828675, -67906143, -20200140,
        193147811, -251361661, 154813210, -47956199, 6042465,
        -17379, 60273, 24987353, -61455449, 62729639, -29820969, 5402925
    };

    typedef struct packed {
        logic signed [stp_pkg::TORQUE_W-1:0] torque;
        stp_pkg::stp_status_t                status;
    } torque_word_t;

    logic clk;
    logic rst_n;

    stp_cfg_if cfg_bus ();
    stp_in_if  angle_bus ();
    stp_out_if torque_bus ();

    spring_torque_polynomial dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .sample (angle_bus),
        .result (torque_bus)
    );

    torque_word_t                torque_due [$];
    logic [stp_pkg::TYPE_W-1:0]  spring_sel;
    bit                          idle_on;
    int                          hold_cycles;
    int                          cycle_count;
    int                          error_count;
    int                          words_sent;
    int                          type_writes;
    int                          n_ok;
    int                          n_no_dir;
    int                          n_no_type;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic torque_word_t horner_torque(
        input logic [stp_pkg::TYPE_W-1:0]         sel,
        input logic signed [stp_pkg::ANGLE_W-1:0] ang,
        input logic [stp_pkg::DIR_W-1:0]          dir);
        torque_word_t w;
        longint       x;
        longint       acc;
        int           curve;
        int           n;
        int           base;
        w.torque = '0;
        w.status = stp_pkg::ST_OK;
        if (sel >= stp_pkg::SPRING_NONE)
            w.status = stp_pkg::ST_NO_TYPE;
        else if (dir > stp_pkg::DIR_DEC)
            w.status = stp_pkg::ST_NO_DIR;
        else
        begin
            curve = 2 * int'(sel) + int'(dir);
            n     = CURVE_TERMS[curve];
            if (n > TERM_CAP)
                n = TERM_CAP;
            base = CURVE_BASE[curve];
            x    = ang;
            acc  = HORNER_COEF[base + n - 1];
            for (int k = n - 1; k > 0; k--)
            begin
                acc = HORNER_COEF[base + k - 1]
                      + ((acc * x + ROUND_HALF) >>> stp_pkg::ROUND_SH);
                if (acc > ACC_LIMIT)
                    acc = ACC_LIMIT;
                else if (acc < -ACC_LIMIT)
                    acc = -ACC_LIMIT;
            end
            if (acc > TORQUE_HI)
                acc = TORQUE_HI;
            else if (acc < TORQUE_LO)
                acc = TORQUE_LO;
            w.torque = acc[stp_pkg::TORQUE_W-1:0];
        end
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [stp_pkg::ANGLE_W-1:0] pick_angle();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 55)
            v = int'($urandom_range(0, 125 << 16)) - (5 << 16);
        else if (r < 75)
            v = int'($urandom());
        else if (r < 90)
            v = int'($urandom_range(0, 1 << 18)) - (1 << 17);
        else
        begin
            case ($urandom_range(0, 5))
                0:       v = int'(ANGLE_MAX);
                1:       v = -8388608;
                2:       v = 0;
                3:       v = -1;
                4:       v = 1;
                default: v = 64 << 16;
            endcase
        end
        return v[stp_pkg::ANGLE_W-1:0];
    endfunction

    function automatic logic [stp_pkg::DIR_W-1:0] pick_dir();
        if ($urandom_range(0, 99) < 85)
            return stp_pkg::DIR_W'($urandom_range(0, 1));
        return stp_pkg::DIR_W'($urandom_range(2, 3));
    endfunction

    task automatic send_word(input logic signed [stp_pkg::ANGLE_W-1:0] ang,
                             input logic [stp_pkg::DIR_W-1:0] dir);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            angle_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        angle_bus.angle     = ang;
        angle_bus.direction = dir;
        angle_bus.valid     = 1'b1;
        do
            @(posedge clk);
        while (!angle_bus.ready);
        torque_due.push_back(horner_torque(spring_sel, ang, dir));
        words_sent++;
        @(negedge clk);
    endtask

    // drop valid and hold until every expected word is back
    task automatic drain_results();
        angle_bus.valid = 1'b0;
        while (torque_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_spring_type(input logic [stp_pkg::TYPE_W-1:0] value);
        drain_results();
        repeat (24) @(negedge clk);
        cfg_bus.data  = value;
        cfg_bus.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        spring_sel = value;
        type_writes++;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic test_unset_type();
        send_word(ANGLE_MAX, DIR_INC);
        send_word(ANGLE_MIN, stp_pkg::DIR_DEC);
        send_word(24'sd0, DIR_NONE3);
        drain_results();
    endtask

    task automatic test_curve_extremes();
        for (int t = 0; t < 4; t++)
        begin
            write_spring_type(stp_pkg::TYPE_W'(t));
            send_word(24'sd0, DIR_INC);
            send_word(ANGLE_MAX, stp_pkg::DIR_DEC);
            send_word(ANGLE_MIN, DIR_INC);
            send_word(24'sh2D0000, stp_pkg::DIR_W'(t & 1));
            send_word(-24'sd1, (t & 1) ? DIR_NONE3 : DIR_NONE);
        end
        write_spring_type(3'd7);
        send_word(ANGLE_MIN, DIR_NONE3);
        send_word(24'sd1, DIR_INC);
        drain_results();
    endtask

    task automatic test_random_sweep();
        logic [stp_pkg::TYPE_W-1:0] plan [0:9];
        plan = '{3'd3, 3'd0, 3'd6, 3'd1, 3'd2, 3'd4, 3'd0, 3'd3, 3'd7, 3'd1};
        for (int p = 0; p < 10; p++)
        begin
            write_spring_type(plan[p]);
            repeat (88) send_word(pick_angle(), pick_dir());
        end
        drain_results();
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        write_spring_type(stp_pkg::TYPE_W'($urandom_range(0, 3)));
        repeat (65) send_word(pick_angle(), pick_dir());
        drain_results();
        write_spring_type(stp_pkg::TYPE_W'($urandom_range(0, 3)));
        repeat (65) send_word(pick_angle(), pick_dir());
        drain_results();
        idle_on = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            torque_bus.ready = 1'b0;
            hold_cycles--;
        end
        else if (idle_on && $urandom_range(0, 99) < 25)
        begin
            torque_bus.ready = 1'b0;
            hold_cycles = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                       : $urandom_range(8, 40);
        end
        else
            torque_bus.ready = 1'b1;
    end

    always @(posedge clk)
    begin
        torque_word_t exp_w;
        if (rst_n && torque_bus.valid && torque_bus.ready)
        begin
            if (torque_due.size() == 0)
            begin
                $error("unexpected word: torque %0d status %0d",
                       torque_bus.torque, torque_bus.status);
                error_count++;
            end
            else
            begin
                exp_w = torque_due.pop_front();
                if (torque_bus.torque !== exp_w.torque)
                begin
                    $error("torque: expected %0d, actual %0d", exp_w.torque, torque_bus.torque);
                    error_count++;
                end
                if (torque_bus.status !== exp_w.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_w.status, torque_bus.status);
                    error_count++;
                end
                case (exp_w.status)
                    stp_pkg::ST_OK:     n_ok++;
                    stp_pkg::ST_NO_DIR: n_no_dir++;
                    default:            n_no_type++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, torque_due.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.data        = '0;
        angle_bus.valid     = 1'b0;
        angle_bus.angle     = '0;
        angle_bus.direction = '0;
        torque_bus.ready    = 1'b0;
        spring_sel          = stp_pkg::SPRING_NONE;
        idle_on             = 1'b1;
        hold_cycles         = 0;
        cycle_count         = 0;
        error_count         = 0;
        words_sent          = 0;
        type_writes         = 0;
        n_ok                = 0;
        n_no_dir            = 0;
        n_no_type           = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_unset_type();
        test_curve_extremes();
        test_random_sweep();
        test_streaming();

        drain_results();
        repeat (30) @(posedge clk);
        $display("Sent %0d angle words over %0d spring-type writes.", words_sent, type_writes);
        $display("Checked %0d evaluated, %0d unspecified-direction, %0d no-type results.",
                 n_ok, n_no_dir, n_no_type);
        if (error_count == 0 && torque_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
